// ===== rtl/core/lvbi_pkg.sv =====
// Shared types, code patterns and helper functions of the LaserDisc VBI decoder.
`default_nettype none

package lvbi_pkg;

    // Field widths
    localparam int LVBI_WORD_W  = 24;
    localparam int LVBI_LEAD_W  = 2;
    localparam int LVBI_FOUND_W = 7;
    localparam int LVBI_USER_W  = 16;
    localparam int LVBI_PIC_W   = 20;
    localparam int LVBI_CHAP_W  = 8;
    localparam int LVBI_TC_W    = 12;
    localparam int LVBI_STAT_W  = 7;
    localparam int LVBI_AUD_W   = 4;
    localparam int LVBI_MODE_W  = 4;
    localparam int LVBI_SECS_W  = 8;
    localparam int LVBI_CPIC_W  = 8;

    typedef logic [LVBI_WORD_W-1:0] t_word;

    // Code patterns: a code is present when every bit of its pattern is set
    localparam t_word LVBI_LEAD_IN   = 24'h88FFFF;
    localparam t_word LVBI_LEAD_OUT  = 24'h80EEEE;
    localparam t_word LVBI_USER_CODE = 24'h80D000;
    localparam t_word LVBI_CLV_TIME  = 24'hF0DD00;
    localparam t_word LVBI_CAV_PIC   = 24'hF00000;
    localparam t_word LVBI_PIC_STOP  = 24'h82CFFF;
    localparam t_word LVBI_CHAPTER   = 24'h800DDD;
    localparam t_word LVBI_STATUS_A  = 24'h8DC000;
    localparam t_word LVBI_STATUS_B  = 24'h8BA000;
    localparam t_word LVBI_CX_ON     = 24'h0DC000;
    localparam t_word LVBI_CLV_PIC   = 24'h80E000;
    localparam t_word LVBI_CLV_CODE  = 24'h87FFFF;

    // Bit positions in found_flags
    localparam int FND_USER   = 0;
    localparam int FND_PIC    = 1;
    localparam int FND_STOP   = 2;
    localparam int FND_CHAP   = 3;
    localparam int FND_TC     = 4;
    localparam int FND_STATUS = 5;
    localparam int FND_CPIC   = 6;

    // Sound mode codes
    localparam logic [LVBI_MODE_W-1:0] SND_STEREO   = 4'd0;
    localparam logic [LVBI_MODE_W-1:0] SND_MONO     = 4'd1;
    localparam logic [LVBI_MODE_W-1:0] SND_FUTURE   = 4'd2;
    localparam logic [LVBI_MODE_W-1:0] SND_BIL      = 4'd3;
    localparam logic [LVBI_MODE_W-1:0] SND_ST_ST    = 4'd4;
    localparam logic [LVBI_MODE_W-1:0] SND_ST_BIL   = 4'd5;
    localparam logic [LVBI_MODE_W-1:0] SND_CROSS    = 4'd6;
    localparam logic [LVBI_MODE_W-1:0] SND_BIL_BIL  = 4'd7;
    localparam logic [LVBI_MODE_W-1:0] SND_MONO_DMP = 4'd8;
    localparam logic [LVBI_MODE_W-1:0] SND_ST_DMP   = 4'd9;
    localparam logic [LVBI_MODE_W-1:0] SND_BIL_DMP  = 4'd10;

    // Three code words of one field
    typedef struct packed {
        t_word line_a;
        t_word line_b;
        t_word line_c;
    } t_vbi_words;

    // One decoded result
    typedef struct packed {
        logic                    disc_is_clv;
        logic [LVBI_LEAD_W-1:0]  lead_flags;
        logic [LVBI_FOUND_W-1:0] found_flags;
        logic [LVBI_USER_W-1:0]  user_code;
        logic [LVBI_PIC_W-1:0]   picture_number;
        logic [LVBI_CHAP_W-1:0]  chapter_value;
        logic [LVBI_TC_W-1:0]    time_code;
        logic [LVBI_STAT_W-1:0]  status_flags;
        logic [LVBI_AUD_W-1:0]   audio_status;
        logic [LVBI_MODE_W-1:0]  sound_mode;
        logic [LVBI_SECS_W-1:0]  clv_seconds;
        logic [LVBI_CPIC_W-1:0]  clv_picture;
    } t_vbi_result;

    function automatic logic has_code(input t_word word, input t_word pattern);
        return (word & pattern) == pattern;
    endfunction

    // Audio status to sound mode
    function automatic logic [LVBI_MODE_W-1:0] sound_lookup(
        input logic [LVBI_AUD_W-1:0] audio
    );
        logic [LVBI_MODE_W-1:0] mode;
        case (audio)
            4'd0:    mode = SND_STEREO;
            4'd1:    mode = SND_MONO;
            4'd2:    mode = SND_FUTURE;
            4'd3:    mode = SND_BIL;
            4'd4:    mode = SND_ST_ST;
            4'd5:    mode = SND_ST_BIL;
            4'd6:    mode = SND_CROSS;
            4'd7:    mode = SND_BIL_BIL;
            4'd8:    mode = SND_MONO_DMP;
            4'd9:    mode = SND_MONO_DMP;
            4'd10:   mode = SND_FUTURE;
            4'd11:   mode = SND_MONO_DMP;
            4'd12:   mode = SND_ST_DMP;
            4'd13:   mode = SND_ST_DMP;
            4'd14:   mode = SND_BIL_DMP;
            4'd15:   mode = SND_BIL_DMP;
            default: mode = SND_STEREO;
        endcase
        return mode;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lvbi_if.sv =====
// Request channel interfaces: VBI code words in, decoded result out.
`default_nettype none

interface lvbi_in_if import lvbi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LVBI_WORD_W-1:0] vbi_line_a;
    logic [LVBI_WORD_W-1:0] vbi_line_b;
    logic [LVBI_WORD_W-1:0] vbi_line_c;

    modport source (output valid, output vbi_line_a, output vbi_line_b,
                    output vbi_line_c, input ready);
    modport sink   (input valid, input vbi_line_a, input vbi_line_b,
                    input vbi_line_c, output ready);
endinterface

interface lvbi_out_if import lvbi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    disc_is_clv;
    logic [LVBI_LEAD_W-1:0]  lead_flags;
    logic [LVBI_FOUND_W-1:0] found_flags;
    logic [LVBI_USER_W-1:0]  user_code;
    logic [LVBI_PIC_W-1:0]   picture_number;
    logic [LVBI_CHAP_W-1:0]  chapter_value;
    logic [LVBI_TC_W-1:0]    time_code;
    logic [LVBI_STAT_W-1:0]  status_flags;
    logic [LVBI_AUD_W-1:0]   audio_status;
    logic [LVBI_MODE_W-1:0]  sound_mode;
    logic [LVBI_SECS_W-1:0]  clv_seconds;
    logic [LVBI_CPIC_W-1:0]  clv_picture;

    modport source (output valid, output disc_is_clv, output lead_flags,
                    output found_flags, output user_code, output picture_number,
                    output chapter_value, output time_code, output status_flags,
                    output audio_status, output sound_mode, output clv_seconds,
                    output clv_picture, input ready);
    modport sink   (input valid, input disc_is_clv, input lead_flags,
                    input found_flags, input user_code, input picture_number,
                    input chapter_value, input time_code, input status_flags,
                    input audio_status, input sound_mode, input clv_seconds,
                    input clv_picture, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lvbi_in_stage.sv =====
// Input register: captures the three code words of one field.
`default_nettype none

module lvbi_in_stage import lvbi_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lvbi_in_if.sink          i_in,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_vbi_words       o_words
);

    logic       r_valid;
    t_vbi_words r_words;
    logic       n_valid;
    logic       w_load;

    // Stage takes a request when empty or when its contents move on
    assign i_in.ready = !r_valid || i_ready;
    assign w_load     = i_in.valid && i_in.ready;
    assign n_valid    = w_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_words.line_a <= i_in.vbi_line_a;
            r_words.line_b <= i_in.vbi_line_b;
            r_words.line_c <= i_in.vbi_line_c;
        end
    end

    assign o_valid = r_valid;
    assign o_words = r_words;

endmodule

`default_nettype wire

// ===== rtl/core/lvbi_decode.sv =====
// Mask-and-slice decode of one field's three code words into a result.
`default_nettype none

module lvbi_decode import lvbi_pkg::*; (
    input  wire t_vbi_words  i_words,
    output t_vbi_result      o_result
);

    t_word                   l16, l17, l18;
    logic                    w_clv;
    logic [LVBI_LEAD_W-1:0]  w_lead;
    logic                    w_pic17, w_pic18, w_chap17, w_chap18, w_tc17, w_tc18;
    logic                    w_user, w_stop, w_stat, w_cpic;
    logic [3:0]              w_x3, w_x4;
    logic [LVBI_AUD_W-1:0]   w_audio;

    assign l16 = i_words.line_a;
    assign l17 = i_words.line_b;
    assign l18 = i_words.line_c;

    // Code presence
    assign w_lead[0] = has_code(l17, LVBI_LEAD_IN)  || has_code(l18, LVBI_LEAD_IN);
    assign w_lead[1] = has_code(l17, LVBI_LEAD_OUT) || has_code(l18, LVBI_LEAD_OUT);
    assign w_clv     = has_code(l17, LVBI_CLV_TIME) || has_code(l17, LVBI_CLV_CODE);
    assign w_user    = (|w_lead) && has_code(l16, LVBI_USER_CODE);
    assign w_pic17   = !w_clv && has_code(l17, LVBI_CAV_PIC);
    assign w_pic18   = !w_clv && has_code(l18, LVBI_CAV_PIC);
    assign w_stop    = !w_clv && (has_code(l16, LVBI_PIC_STOP) ||
                                  has_code(l17, LVBI_PIC_STOP));
    assign w_chap17  = !w_clv && has_code(l17, LVBI_CHAPTER);
    assign w_chap18  = has_code(l18, LVBI_CHAPTER);
    assign w_tc17    = w_clv && has_code(l17, LVBI_CLV_TIME);
    assign w_tc18    = w_clv && has_code(l18, LVBI_CLV_TIME);
    assign w_stat    = has_code(l16, LVBI_STATUS_A) || has_code(l16, LVBI_STATUS_B);
    assign w_cpic    = w_clv && has_code(l16, LVBI_CLV_PIC);

    // Programme status nibbles
    assign w_x3    = l16[11:8];
    assign w_x4    = l16[7:4];
    assign w_audio = {w_x4[3], w_x3[3], w_x4[2], w_x4[0]};

    // Assemble result; later line wins, absent codes read zero
    always_comb begin
        o_result             = '0;
        o_result.disc_is_clv = w_clv;
        o_result.lead_flags  = w_lead;

        o_result.found_flags[FND_USER]   = w_user;
        o_result.found_flags[FND_PIC]    = w_pic17 || w_pic18;
        o_result.found_flags[FND_STOP]   = w_stop;
        o_result.found_flags[FND_CHAP]   = w_chap17 || w_chap18;
        o_result.found_flags[FND_TC]     = w_tc17 || w_tc18;
        o_result.found_flags[FND_STATUS] = w_stat;
        o_result.found_flags[FND_CPIC]   = w_cpic;

        if (w_user) begin
            o_result.user_code = {l16[19:16], l16[11:0]};
        end

        if (w_pic18) begin
            o_result.picture_number = l18[19:0];
        end else if (w_pic17) begin
            o_result.picture_number = l17[19:0];
        end

        if (w_chap18) begin
            o_result.chapter_value = l18[19:12];
        end else if (w_chap17) begin
            o_result.chapter_value = l17[19:12];
        end

        if (w_tc18) begin
            o_result.time_code = {l18[19:16], l18[7:0]};
        end else if (w_tc17) begin
            o_result.time_code = {l17[19:16], l17[7:0]};
        end

        if (w_stat) begin
            o_result.status_flags = {w_audio[2], w_audio[3], w_x4[1], w_x3[2],
                                     !w_x3[1], !w_x3[0], has_code(l16, LVBI_CX_ON)};
            o_result.audio_status = w_audio;
            o_result.sound_mode   = sound_lookup(w_audio);
        end

        if (w_cpic) begin
            o_result.clv_seconds = {l16[19:16], l16[11:8]};
            o_result.clv_picture = l16[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lvbi_out_stage.sv =====
// Result register: holds one decoded result until the sink takes it.
`default_nettype none

module lvbi_out_stage import lvbi_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire t_vbi_result  i_result,
    output logic              o_ready,
    lvbi_out_if.source        o_out
);

    logic        r_valid;
    t_vbi_result r_result;
    logic        n_valid;
    logic        w_load;

    // Load when empty or when the held result is being taken
    assign o_ready = !r_valid || o_out.ready;
    assign w_load  = i_valid && o_ready;
    assign n_valid = w_load || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    // Drive the channel
    assign o_out.valid          = r_valid;
    assign o_out.disc_is_clv    = r_result.disc_is_clv;
    assign o_out.lead_flags     = r_result.lead_flags;
    assign o_out.found_flags    = r_result.found_flags;
    assign o_out.user_code      = r_result.user_code;
    assign o_out.picture_number = r_result.picture_number;
    assign o_out.chapter_value  = r_result.chapter_value;
    assign o_out.time_code      = r_result.time_code;
    assign o_out.status_flags   = r_result.status_flags;
    assign o_out.audio_status   = r_result.audio_status;
    assign o_out.sound_mode     = r_result.sound_mode;
    assign o_out.clv_seconds    = r_result.clv_seconds;
    assign o_out.clv_picture    = r_result.clv_picture;

endmodule

`default_nettype wire

// ===== rtl/core/laserdisc_vbi_decoder_core.sv =====
// Top level of the LaserDisc VBI code decoder: input register, decode, result register.
//
//  channel  dir  payload                                   request taken when
//  i_in     in   vbi_line_a/b/c (lines 16, 17, 18)         valid && ready
//  o_out    out  disc type, lead, found, codes, status      valid && ready
//
// One request per cycle sustained while o_out is not stalled; taking a request
// loads the input register, and its decode is loaded into the result register
// once that register is free, from where the result is offered on o_out.
// Reset empties both registers; no clearing pass, no stored state beyond them.
// A stall on o_out holds the result register; ready on i_in falls only when
// both registers are full and the sink is not taking.
`default_nettype none

module laserdisc_vbi_decoder_core import lvbi_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lvbi_in_if.sink     i_in,
    lvbi_out_if.source  o_out
);

    logic        w_s1_valid;
    logic        w_s2_ready;
    t_vbi_words  w_words;
    t_vbi_result w_result;

    lvbi_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_s2_ready),
        .o_valid (w_s1_valid),
        .o_words (w_words)
    );

    lvbi_decode u_decode (
        .i_words  (w_words),
        .o_result (w_result)
    );

    lvbi_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s1_valid),
        .i_result (w_result),
        .o_ready  (w_s2_ready),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the VBI decoder core: directed and random fields checked against a decode predictor.
module tb_top;
    import lvbi_pkg::*;

    localparam int RAND_FIELDS  = 730;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // Bit positions of lead_flags and status_flags
    localparam int LEAD_IN_BIT   = 0;
    localparam int LEAD_OUT_BIT  = 1;
    localparam int ST_CX         = 0;
    localparam int ST_TWELVE     = 1;
    localparam int ST_SIDE_ONE   = 2;
    localparam int ST_TELETEXT   = 3;
    localparam int ST_DIGITAL    = 4;
    localparam int ST_DUMP       = 5;
    localparam int ST_FM_MUX     = 6;

    // Sound mode for each audio status value
    localparam logic [LVBI_MODE_W-1:0] MODE_OF_AUDIO [16] = '{
        SND_STEREO, SND_MONO, SND_FUTURE, SND_BIL, SND_ST_ST, SND_ST_BIL, SND_CROSS,
        SND_BIL_BIL, SND_MONO_DMP, SND_MONO_DMP, SND_FUTURE, SND_MONO_DMP,
        SND_ST_DMP, SND_ST_DMP, SND_BIL_DMP, SND_BIL_DMP
    };

    // All code patterns, used to build well-formed random words
    localparam t_word CODE_SET [12] = '{
        LVBI_LEAD_IN, LVBI_LEAD_OUT, LVBI_USER_CODE, LVBI_CLV_TIME, LVBI_CAV_PIC,
        LVBI_PIC_STOP, LVBI_CHAPTER, LVBI_STATUS_A, LVBI_STATUS_B, LVBI_CX_ON,
        LVBI_CLV_PIC, LVBI_CLV_CODE
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lvbi_in_if  in_ch ();
    lvbi_out_if out_ch ();

    laserdisc_vbi_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_vbi_result pending_decodes [$];
    int          mismatch_cnt = 0;
    int          result_cnt   = 0;
    bit          sink_eager   = 1'b0;
    bit          hold_off_req = 1'b0;

    // Directed table
    t_word       row_a [$];
    t_word       row_b [$];
    t_word       row_c [$];
    bit          row_typed [$];
    t_vbi_result row_want [$];

    function automatic bit carries(input t_word word, input t_word mask);
        return (word & mask) == mask;
    endfunction

    // Predicted decode of one field
    function automatic t_vbi_result decode_field(input t_vbi_words w);
        t_vbi_result r;
        t_word       l16;
        t_word       l17;
        t_word       l18;
        logic [3:0]  x3;
        logic [3:0]  x4;
        logic        clv;
        r   = '0;
        l16 = w.line_a;
        l17 = w.line_b;
        l18 = w.line_c;

        r.lead_flags[LEAD_IN_BIT]  = carries(l17, LVBI_LEAD_IN) || carries(l18, LVBI_LEAD_IN);
        r.lead_flags[LEAD_OUT_BIT] = carries(l17, LVBI_LEAD_OUT) || carries(l18, LVBI_LEAD_OUT);

        // user code only inside lead-in or lead-out
        if (r.lead_flags != '0 && carries(l16, LVBI_USER_CODE)) begin
            r.user_code = {l16[19:16], l16[11:0]};
            r.found_flags[FND_USER] = 1'b1;
        end

        clv = carries(l17, LVBI_CLV_TIME) || carries(l17, LVBI_CLV_CODE);
        r.disc_is_clv = clv;

        // CAV-only codes; later line wins
        if (!clv) begin
            if (carries(l17, LVBI_CAV_PIC)) begin
                r.picture_number = l17[19:0];
                r.found_flags[FND_PIC] = 1'b1;
            end
            if (carries(l18, LVBI_CAV_PIC)) begin
                r.picture_number = l18[19:0];
                r.found_flags[FND_PIC] = 1'b1;
            end
            if (carries(l16, LVBI_PIC_STOP) || carries(l17, LVBI_PIC_STOP))
                r.found_flags[FND_STOP] = 1'b1;
            if (carries(l17, LVBI_CHAPTER)) begin
                r.chapter_value = l17[19:12];
                r.found_flags[FND_CHAP] = 1'b1;
            end
        end
        // chapter on line 18 counts on either disc type
        if (carries(l18, LVBI_CHAPTER)) begin
            r.chapter_value = l18[19:12];
            r.found_flags[FND_CHAP] = 1'b1;
        end

        // CLV time code
        if (clv) begin
            if (carries(l17, LVBI_CLV_TIME)) begin
                r.time_code = {l17[19:16], l17[7:0]};
                r.found_flags[FND_TC] = 1'b1;
            end
            if (carries(l18, LVBI_CLV_TIME)) begin
                r.time_code = {l18[19:16], l18[7:0]};
                r.found_flags[FND_TC] = 1'b1;
            end
        end

        // programme status and audio
        if (carries(l16, LVBI_STATUS_A) || carries(l16, LVBI_STATUS_B)) begin
            x3 = l16[11:8];
            x4 = l16[7:4];
            r.found_flags[FND_STATUS]    = 1'b1;
            r.status_flags[ST_CX]        = carries(l16, LVBI_CX_ON);
            r.status_flags[ST_TWELVE]    = !x3[0];
            r.status_flags[ST_SIDE_ONE]  = !x3[1];
            r.status_flags[ST_TELETEXT]  = x3[2];
            r.status_flags[ST_DIGITAL]   = x4[1];
            r.audio_status               = {x4[3], x3[3], x4[2], x4[0]};
            r.sound_mode                 = MODE_OF_AUDIO[r.audio_status];
            r.status_flags[ST_DUMP]      = r.audio_status[3];
            r.status_flags[ST_FM_MUX]    = r.audio_status[2];
        end

        // CLV picture number
        if (clv && carries(l16, LVBI_CLV_PIC)) begin
            r.clv_seconds = {l16[19:16], l16[11:8]};
            r.clv_picture = l16[7:0];
            r.found_flags[FND_CPIC] = 1'b1;
        end
        return r;
    endfunction

    function automatic t_vbi_result want_of(
        input logic                    clv,
        input logic [LVBI_LEAD_W-1:0]  lead,
        input logic [LVBI_FOUND_W-1:0] found,
        input logic [LVBI_USER_W-1:0]  user,
        input logic [LVBI_PIC_W-1:0]   pic,
        input logic [LVBI_CHAP_W-1:0]  chap,
        input logic [LVBI_TC_W-1:0]    tc,
        input logic [LVBI_STAT_W-1:0]  status,
        input logic [LVBI_AUD_W-1:0]   audio,
        input logic [LVBI_MODE_W-1:0]  mode,
        input logic [LVBI_SECS_W-1:0]  secs,
        input logic [LVBI_CPIC_W-1:0]  cpic
    );
        return {clv, lead, found, user, pic, chap, tc, status, audio, mode, secs, cpic};
    endfunction

    task automatic add_row(input t_word a, input t_word b, input t_word c,
                           input bit typed, input t_vbi_result want);
        row_a.push_back(a);
        row_b.push_back(b);
        row_c.push_back(c);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Random code word: mostly a code pattern over sparse filler
    function automatic t_word rand_word();
        t_word w;
        int    pick;
        w    = t_word'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 65)
            w = (w & t_word'($urandom())) | CODE_SET[$urandom_range(0, 11)];
        else if (pick < 80)
            w = ((w & t_word'($urandom())) | CODE_SET[$urandom_range(0, 11)]) &
                ~(t_word'(1) << $urandom_range(0, 23));
        else if (pick < 85)
            w = '0;
        else if (pick < 88)
            w = '1;
        return w;
    endfunction

    task automatic report(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("result %0d: %s", result_cnt, msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want)
            report($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // Drive one field after an optional gap, wait until the request is taken
    task automatic send_field(input t_vbi_words w, input t_vbi_result want, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.vbi_line_a <= w.line_a;
        in_ch.vbi_line_b <= w.line_b;
        in_ch.vbi_line_c <= w.line_c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_decodes.push_back(want);
    endtask

    // Result side: random stalls, quiet stretches, one long hold-off
    initial begin : sink_ctrl
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sink_eager || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_vbi_result got;
        t_vbi_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.disc_is_clv    = out_ch.disc_is_clv;
            got.lead_flags     = out_ch.lead_flags;
            got.found_flags    = out_ch.found_flags;
            got.user_code      = out_ch.user_code;
            got.picture_number = out_ch.picture_number;
            got.chapter_value  = out_ch.chapter_value;
            got.time_code      = out_ch.time_code;
            got.status_flags   = out_ch.status_flags;
            got.audio_status   = out_ch.audio_status;
            got.sound_mode     = out_ch.sound_mode;
            got.clv_seconds    = out_ch.clv_seconds;
            got.clv_picture    = out_ch.clv_picture;
            if (pending_decodes.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                want = pending_decodes.pop_front();
                cmp_field("disc_is_clv", want.disc_is_clv, got.disc_is_clv);
                cmp_field("lead_flags", want.lead_flags, got.lead_flags);
                cmp_field("found_flags", want.found_flags, got.found_flags);
                cmp_field("user_code", want.user_code, got.user_code);
                cmp_field("picture_number", want.picture_number, got.picture_number);
                cmp_field("chapter_value", want.chapter_value, got.chapter_value);
                cmp_field("time_code", want.time_code, got.time_code);
                cmp_field("status_flags", want.status_flags, got.status_flags);
                cmp_field("audio_status", want.audio_status, got.audio_status);
                cmp_field("sound_mode", want.sound_mode, got.sound_mode);
                cmp_field("clv_seconds", want.clv_seconds, got.clv_seconds);
                cmp_field("clv_picture", want.clv_picture, got.clv_picture);
            end
            result_cnt++;
        end
    end

    // Stimulus: directed table, then random fields
    initial begin : stimulus
        t_vbi_words w;
        t_vbi_result want;
        int n;
        int gap;
        bit quiet;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.vbi_line_a = '0;
        in_ch.vbi_line_b = '0;
        in_ch.vbi_line_c = '0;

        // empty field and all bits set
        add_row(24'h000000, 24'h000000, 24'h000000, 1'b1, '0);
        add_row(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
                want_of(1'b1, 2'b11, 7'h79, 16'hFFFF, 20'h0, 8'hFF, 12'hFFF,
                        7'h79, 4'hF, SND_BIL_DMP, 8'hFF, 8'hFF));
        // CAV picture number on line 18 alone
        add_row(24'h000000, 24'h000000, 24'hF12345, 1'b1,
                want_of(1'b0, 2'b00, 7'(1 << FND_PIC), 16'h0, 20'h12345, 8'h0, 12'h0,
                        7'h0, 4'h0, SND_STEREO, 8'h0, 8'h0));
        // lead-in / lead-out and user code, x1 above 7, user code without lead
        add_row(24'h85D123, 24'h88FFFF, 24'h000000, 1'b0, '0);
        add_row(24'h8FD7AB, 24'h000000, 24'h80EEEE, 1'b0, '0);
        add_row(24'h80D000, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h000000, 24'h80EEEE, 24'h88FFFF, 1'b0, '0);
        // CLV disc by either code, CAV picture ignored on CLV
        add_row(24'h000000, 24'h87FFFF, 24'hF3DD45, 1'b0, '0);
        add_row(24'h000000, 24'hF2DD30, 24'hF54321, 1'b0, '0);
        // picture number on both lines: line 18 wins
        add_row(24'h000000, 24'hF00001, 24'hFABCDE, 1'b0, '0);
        // picture stop on 16, on 17, and ignored on CLV
        add_row(24'h82CFFF, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h000000, 24'h82CFFF, 24'h000000, 1'b0, '0);
        add_row(24'h82CFFF, 24'hF2DFFF, 24'h000000, 1'b0, '0);
        // chapter on 17, on 18 for CLV, on both
        add_row(24'h000000, 24'h8A5DDD, 24'h000000, 1'b0, '0);
        add_row(24'h000000, 24'h87FFFF, 24'h8A3DDD, 1'b0, '0);
        add_row(24'h000000, 24'h8A5DDD, 24'h8B7DDD, 1'b0, '0);
        // status words with assorted audio bits
        add_row(24'h8DC000, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h8BAFF0, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h8BA8A0, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h8DC050, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h8BA090, 24'h000000, 24'h000000, 1'b0, '0);
        // CLV picture number on CLV and on CAV, time code on CAV
        add_row(24'h8AE37C, 24'hF0DD00, 24'h000000, 1'b0, '0);
        add_row(24'h8AE37C, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(24'h000000, 24'h000000, 24'hF0DD00, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (row_a[k]) begin
            w.line_a = row_a[k];
            w.line_b = row_b[k];
            w.line_c = row_c[k];
            want = row_typed[k] ? row_want[k] : decode_field(w);
            gap  = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
            send_field(w, want, gap);
        end

        for (n = 0; n < RAND_FIELDS; n++) begin
            quiet      = (n >= 200 && n < 280);
            sink_eager = quiet;
            if (n == 450)
                hold_off_req = 1'b1;
            if (quiet || (n >= 450 && n < 470) || $urandom_range(0, 2) != 0)
                gap = 0;
            else
                gap = idle_len();
            w.line_a = rand_word();
            w.line_b = rand_word();
            w.line_c = rand_word();
            send_field(w, decode_field(w), gap);
        end
        in_ch.valid <= 1'b0;
        sink_eager = 1'b0;

        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lvbi_pkg.sv
rtl/core/lvbi_if.sv
rtl/core/lvbi_in_stage.sv
rtl/core/lvbi_decode.sv
rtl/core/lvbi_out_stage.sv
rtl/core/laserdisc_vbi_decoder_core.sv
tb/tb_top.sv
